// ----- src/assert_macros.svh -----
// assertion helpers shared by the rtl
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, clocked on clk, off during reset
`define ASSERT_IMPL(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, clocked on clk, off during reset
`define ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ----- src/cssq_pkg.sv -----
// ----------------------------------------------------------------------------
// cssq_pkg
// shared constants and register codes of the convex shape support query
// ----------------------------------------------------------------------------
`default_nettype none

package cssq_pkg;

    localparam int COORD_WIDTH_DEF = 32;
    localparam int REG_W           = 31;
    localparam int KIND_W          = 2;
    localparam int IDX_W           = 3;

    localparam logic [KIND_W-1:0] KIND_SPHERE = 2'd0;
    localparam logic [KIND_W-1:0] KIND_BOX    = 2'd1;
    localparam logic [KIND_W-1:0] KIND_CYL    = 2'd2;
    localparam logic [KIND_W-1:0] KIND_NONE   = 2'd3;

    localparam logic [IDX_W-1:0] REG_KIND   = 3'd0;
    localparam logic [IDX_W-1:0] REG_RADIUS = 3'd1;
    localparam logic [IDX_W-1:0] REG_HALF_X = 3'd2;
    localparam logic [IDX_W-1:0] REG_HALF_Y = 3'd3;
    localparam logic [IDX_W-1:0] REG_HALF_Z = 3'd4;
    localparam logic [IDX_W-1:0] REG_HALF_H = 3'd5;

    localparam logic [REG_W-1:0] EXTENT_RESET = 31'd65536;

    typedef logic [REG_W-1:0] extent_t;

endpackage

`default_nettype wire

// ----- src/cssq_in_if.sv -----
// ----------------------------------------------------------------------------
// cssq_in_if
// query channel: one signed 3-vector per transaction
// ----------------------------------------------------------------------------
`default_nettype none

interface cssq_in_if #(
    parameter int COORD_WIDTH = cssq_pkg::COORD_WIDTH_DEF
) ();
    logic                          valid;
    logic                          ready;
    logic signed [COORD_WIDTH-1:0] vec_x;
    logic signed [COORD_WIDTH-1:0] vec_y;
    logic signed [COORD_WIDTH-1:0] vec_z;

    modport source (output valid, output vec_x, output vec_y, output vec_z, input ready);
    modport sink   (input valid, input vec_x, input vec_y, input vec_z, output ready);
endinterface

`default_nettype wire

// ----- src/cssq_out_if.sv -----
// ----------------------------------------------------------------------------
// cssq_out_if
// result channel: support point, projected point and inside flag
// ----------------------------------------------------------------------------
`default_nettype none

interface cssq_out_if #(
    parameter int COORD_WIDTH = cssq_pkg::COORD_WIDTH_DEF
) ();
    logic                          valid;
    logic                          ready;
    logic signed [COORD_WIDTH-1:0] support_x;
    logic signed [COORD_WIDTH-1:0] support_y;
    logic signed [COORD_WIDTH-1:0] support_z;
    logic signed [COORD_WIDTH-1:0] proj_x;
    logic signed [COORD_WIDTH-1:0] proj_y;
    logic signed [COORD_WIDTH-1:0] proj_z;
    logic                          inside_res;

    modport source (output valid, output support_x, output support_y, output support_z,
                    output proj_x, output proj_y, output proj_z, output inside_res,
                    input ready);
    modport sink   (input valid, input support_x, input support_y, input support_z,
                    input proj_x, input proj_y, input proj_z, input inside_res,
                    output ready);
endinterface

`default_nettype wire

// ----- src/cssq_sqrt_cell.sv -----
// ----------------------------------------------------------------------------
// cssq_sqrt_cell
// one stage of the digit-by-digit square root: settles one root bit
// ----------------------------------------------------------------------------
`default_nettype none

module cssq_sqrt_cell #(
    parameter int W = cssq_pkg::COORD_WIDTH_DEF
) (
    input  wire logic             clk,
    input  wire logic             en,
    input  wire logic [2*W-1:0]   x_in,
    input  wire logic [W+1:0]     rem_in,
    input  wire logic [W-1:0]     root_in,
    output logic      [2*W-1:0]   x_out,
    output logic      [W+1:0]     rem_out,
    output logic      [W-1:0]     root_out
);
    logic [2*W-1:0] x_reg,    x_next;
    logic [W+1:0]   rem_reg,  rem_next;
    logic [W-1:0]   root_reg, root_next;
    logic [W+3:0]   acc;
    logic [W+3:0]   trial;
    logic [W+3:0]   diff;
    logic           take;

    always_comb
    begin
        // bring down the next two radicand bits, try root*4+1
        acc       = {rem_in, x_in[2*W-1 -: 2]};
        trial     = {2'b00, root_in, 2'b01};
        take      = (acc >= trial);
        diff      = acc - trial;
        rem_next  = take ? diff[W+1:0] : acc[W+1:0];
        root_next = {root_in[W-2:0], take};
        x_next    = {x_in[2*W-3:0], 2'b00};
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            x_reg    <= x_next;
            rem_reg  <= rem_next;
            root_reg <= root_next;
        end
    end

    assign x_out    = x_reg;
    assign rem_out  = rem_reg;
    assign root_out = root_reg;
endmodule

`default_nettype wire

// ----- src/cssq_div_cell.sv -----
// ----------------------------------------------------------------------------
// cssq_div_cell
// one stage of the restoring divider: settles one quotient bit
// ----------------------------------------------------------------------------
`default_nettype none

module cssq_div_cell #(
    parameter int W = cssq_pkg::COORD_WIDTH_DEF
) (
    input  wire logic                        clk,
    input  wire logic                        en,
    input  wire logic [W-1:0]                d,
    input  wire logic [W-1:0]                rem_in,
    input  wire cssq_pkg::extent_t           num_in,
    input  wire cssq_pkg::extent_t           q_in,
    output logic      [W-1:0]                rem_out,
    output cssq_pkg::extent_t                num_out,
    output cssq_pkg::extent_t                q_out
);
    import cssq_pkg::*;

    logic [W-1:0] rem_reg, rem_next;
    extent_t      num_reg, num_next;
    extent_t      q_reg,   q_next;
    logic [W:0]   acc;
    logic [W:0]   diff;
    logic         ge;

    always_comb
    begin
        acc      = {rem_in, num_in[REG_W-1]};
        ge       = (acc >= {1'b0, d});
        diff     = acc - {1'b0, d};
        rem_next = ge ? diff[W-1:0] : acc[W-1:0];
        num_next = {num_in[REG_W-2:0], 1'b0};
        q_next   = {q_in[REG_W-2:0], ge};
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            rem_reg <= rem_next;
            num_reg <= num_next;
            q_reg   <= q_next;
        end
    end

    assign rem_out = rem_reg;
    assign num_out = num_reg;
    assign q_out   = q_reg;
endmodule

`default_nettype wire

// ----- src/convex_shape_support_query.sv -----
// ----------------------------------------------------------------------------
// convex_shape_support_query
// support point, projection and inside test for a sphere, box or z cylinder
// ----------------------------------------------------------------------------
// throughput: one transaction per cycle while the result sink is ready, fully pipelined
// depth set by the square root chain (one root bit per cell) and the
// divider chain (31 quotient bits, one per cell, three lanes)
// reset: all stage valids clear, shape registers return to sphere, extents 1.0
`default_nettype none

`include "assert_macros.svh"

module convex_shape_support_query #(
    parameter int COORD_WIDTH = cssq_pkg::COORD_WIDTH_DEF
) (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          cfg_wr_en,
    input  wire logic [cssq_pkg::IDX_W-1:0]    cfg_index,
    input  wire logic [cssq_pkg::REG_W-1:0]    cfg_data,
    cssq_in_if.sink                            query,
    cssq_out_if.source                         result
);
    import cssq_pkg::*;

    localparam int W  = COORD_WIDTH;
    localparam int QB = REG_W;
    localparam int PW = W + REG_W;
    localparam int NW = PW + 1;
    localparam int EW = ((W > REG_W) ? W : REG_W) + 1;
    localparam int CW = ((2 * W > 2 * REG_W) ? 2 * W : 2 * REG_W) + 2;

    typedef struct packed {
        logic [2:0][PW-1:0] prod;
        logic [2:0][W-1:0]  fsup;
        logic [2:0][W-1:0]  fprj;
        logic [2:0]         neg;
        logic [2:0]         rad;
        logic               outside;
        logic               in_shape;
        logic [KIND_W-1:0]  kind;
    } side_t;

    typedef struct packed {
        logic [2:0][W-1:0]  fsup;
        logic [2:0][W-1:0]  fprj;
        logic [2:0]         neg;
        logic [2:0]         rad;
        logic               outside;
        logic               in_shape;
        logic               dz;
        logic [W-1:0]       d;
        logic [KIND_W-1:0]  kind;
    } dside_t;

    function automatic logic [W-1:0] sat(input logic neg, input extent_t m);
        logic [EW-1:0] me;
        logic [EW-1:0] lim;
        logic [W-1:0]  r;
        begin
            me  = EW'(m);
            lim = neg ? (EW'(1) << (W - 1)) : ((EW'(1) << (W - 1)) - EW'(1));
            if (me > lim)
                me = lim;
            r = me[W-1:0];
            sat = neg ? (~r + W'(1)) : r;
        end
    endfunction

    // configuration
    logic [KIND_W-1:0] kind_reg;
    extent_t           radius_reg, half_x_reg, half_y_reg, half_z_reg, half_h_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            kind_reg   <= KIND_SPHERE;
            radius_reg <= EXTENT_RESET;
            half_x_reg <= EXTENT_RESET;
            half_y_reg <= EXTENT_RESET;
            half_z_reg <= EXTENT_RESET;
            half_h_reg <= EXTENT_RESET;
        end
        else if (cfg_wr_en)
        begin
            unique case (cfg_index)
                REG_KIND:   kind_reg   <= cfg_data[KIND_W-1:0];
                REG_RADIUS: radius_reg <= cfg_data;
                REG_HALF_X: half_x_reg <= cfg_data;
                REG_HALF_Y: half_y_reg <= cfg_data;
                REG_HALF_Z: half_z_reg <= cfg_data;
                REG_HALF_H: half_h_reg <= cfg_data;
                default:    ;
            endcase
        end
    end

    // whole pipe moves together; output register parts it from the sink
    logic adv;
    logic out_valid_reg;
    assign adv         = !out_valid_reg || result.ready;
    assign query.ready = adv;

    // stage 1: capture, split sign and magnitude
    logic              s1_valid_reg;
    logic [W-1:0]      s1_raw_reg [3];
    logic [W-1:0]      s1_mag_reg [3];
    logic [2:0]        s1_neg_reg;
    logic [KIND_W-1:0] s1_kind_reg;
    extent_t           s1_r_reg, s1_hh_reg;
    extent_t           s1_h_reg [3];
    logic [W-1:0]      in_raw [3];

    assign in_raw[0] = query.vec_x;
    assign in_raw[1] = query.vec_y;
    assign in_raw[2] = query.vec_z;

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            for (int i = 0; i < 3; i++)
            begin
                s1_raw_reg[i] <= in_raw[i];
                s1_neg_reg[i] <= in_raw[i][W-1];
                s1_mag_reg[i] <= in_raw[i][W-1] ? (~in_raw[i] + W'(1)) : in_raw[i];
            end
            s1_kind_reg <= kind_reg;
            s1_r_reg    <= radius_reg;
            s1_hh_reg   <= half_h_reg;
            s1_h_reg[0] <= half_x_reg;
            s1_h_reg[1] <= half_y_reg;
            s1_h_reg[2] <= half_z_reg;
        end
    end

    // stage 2: products, extent and clamp results
    logic              s2_valid_reg;
    logic [2*W-1:0]    s2_sq_reg   [3];
    logic [PW-1:0]     s2_prod_reg [3];
    logic [2*REG_W-1:0] s2_r2_reg;
    logic [W-1:0]      s2_fsup_reg [3], s2_fsup_next [3];
    logic [W-1:0]      s2_fprj_reg [3], s2_fprj_next [3];
    logic [2:0]        s2_neg_reg, s2_rad_reg, s2_rad_next;
    logic [KIND_W-1:0] s2_kind_reg;
    logic              s2_boxin_reg, s2_boxin_next, s2_czin_reg, s2_czin_next;

    always_comb
    begin
        extent_t hsel;
        logic    big;
        logic    zero;
        s2_boxin_next = 1'b1;
        s2_czin_next  = (EW'(s1_mag_reg[2]) <= EW'(s1_hh_reg));
        for (int i = 0; i < 3; i++)
        begin
            hsel = (i == 2 && s1_kind_reg == KIND_CYL) ? s1_hh_reg : s1_h_reg[i];
            big  = (EW'(s1_mag_reg[i]) > EW'(hsel));
            zero = (s1_mag_reg[i] == '0);
            if (EW'(s1_mag_reg[i]) >= EW'(s1_h_reg[i]))
                s2_boxin_next = 1'b0;
            s2_rad_next[i]  = 1'b0;
            s2_fsup_next[i] = '0;
            s2_fprj_next[i] = '0;
            unique case (s1_kind_reg)
                KIND_SPHERE:
                begin
                    s2_rad_next[i]  = 1'b1;
                    s2_fprj_next[i] = s1_raw_reg[i];
                end
                KIND_BOX:
                begin
                    s2_fsup_next[i] = sat(s1_neg_reg[i] || zero, hsel);
                    s2_fprj_next[i] = big ? sat(s1_neg_reg[i], hsel) : s1_raw_reg[i];
                end
                KIND_CYL:
                begin
                    if (i < 2)
                    begin
                        s2_rad_next[i]  = 1'b1;
                        s2_fprj_next[i] = s1_raw_reg[i];
                    end
                    else
                    begin
                        s2_fsup_next[i] = sat(s1_neg_reg[i] || zero, hsel);
                        s2_fprj_next[i] = big ? sat(s1_neg_reg[i], hsel) : s1_raw_reg[i];
                    end
                end
                default: ;
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            for (int i = 0; i < 3; i++)
            begin
                s2_sq_reg[i]   <= (2*W)'(s1_mag_reg[i]) * (2*W)'(s1_mag_reg[i]);
                s2_prod_reg[i] <= PW'(s1_mag_reg[i]) * PW'(s1_r_reg);
                s2_fsup_reg[i] <= s2_fsup_next[i];
                s2_fprj_reg[i] <= s2_fprj_next[i];
            end
            s2_r2_reg    <= (2*REG_W)'(s1_r_reg) * (2*REG_W)'(s1_r_reg);
            s2_neg_reg   <= s1_neg_reg;
            s2_rad_reg   <= s2_rad_next;
            s2_kind_reg  <= s1_kind_reg;
            s2_boxin_reg <= s2_boxin_next;
            s2_czin_reg  <= s2_czin_next;
        end
    end

    // stage 3: squared norm and radial compares
    logic [CW-1:0] n2_sum;
    logic          in_ball, outside;
    side_t         s3_side;

    always_comb
    begin
        n2_sum  = CW'(s2_sq_reg[0]) + CW'(s2_sq_reg[1])
                + ((s2_kind_reg == KIND_SPHERE) ? CW'(s2_sq_reg[2]) : CW'(0));
        in_ball = (n2_sum < CW'(s2_r2_reg));
        outside = (CW'(s2_r2_reg) < n2_sum);
        for (int i = 0; i < 3; i++)
        begin
            s3_side.prod[i] = s2_prod_reg[i];
            s3_side.fsup[i] = s2_fsup_reg[i];
            s3_side.fprj[i] = s2_fprj_reg[i];
        end
        s3_side.neg     = s2_neg_reg;
        s3_side.rad     = s2_rad_reg;
        s3_side.outside = outside;
        s3_side.kind    = s2_kind_reg;
        unique case (s2_kind_reg)
            KIND_SPHERE: s3_side.in_shape = in_ball;
            KIND_BOX:    s3_side.in_shape = s2_boxin_reg;
            KIND_CYL:    s3_side.in_shape = in_ball && s2_czin_reg;
            default:     s3_side.in_shape = 1'b0;
        endcase
    end

    // square root chain, entry 0 is the stage 3 register
    logic           vq_reg [W+1];
    side_t          sd_reg [W+1];
    logic [2*W-1:0] sq_x    [W+1];
    logic [W+1:0]   sq_rem  [W+1];
    logic [W-1:0]   sq_root [W+1];
    logic [2*W-1:0] s3_n2_reg;

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            s3_n2_reg <= n2_sum[2*W-1:0];
            sd_reg[0] <= s3_side;
            for (int k = 1; k <= W; k++)
                sd_reg[k] <= sd_reg[k-1];
        end
    end

    assign sq_x[0]    = s3_n2_reg;
    assign sq_rem[0]  = '0;
    assign sq_root[0] = '0;

    for (genvar k = 0; k < W; k++)
    begin : g_sqrt
        cssq_sqrt_cell #(.W(W)) u_cell (
            .clk      (clk),
            .en       (adv),
            .x_in     (sq_x[k]),
            .rem_in   (sq_rem[k]),
            .root_in  (sq_root[k]),
            .x_out    (sq_x[k+1]),
            .rem_out  (sq_rem[k+1]),
            .root_out (sq_root[k+1])
        );
    end

    // numerators with half-divisor rounding, then divider chain
    logic    vd_reg [QB+1];
    dside_t  ds_reg [QB+1];
    dside_t  ds_next;
    logic [W-1:0] dv_rem [3][QB+1];
    extent_t      dv_num [3][QB+1];
    extent_t      dv_q   [3][QB+1];
    logic [W-1:0] n_rem_next [3];
    extent_t      n_num_next [3];
    logic [NW-1:0] numer;

    always_comb
    begin
        numer = '0;
        for (int i = 0; i < 3; i++)
        begin
            numer         = NW'(sd_reg[W].prod[i]) + NW'(sq_root[W] >> 1);
            n_rem_next[i] = numer[QB +: W];
            n_num_next[i] = numer[QB-1:0];
            ds_next.fsup[i] = sd_reg[W].fsup[i];
            ds_next.fprj[i] = sd_reg[W].fprj[i];
        end
        ds_next.neg      = sd_reg[W].neg;
        ds_next.rad      = sd_reg[W].rad;
        ds_next.outside  = sd_reg[W].outside;
        ds_next.in_shape = sd_reg[W].in_shape;
        ds_next.kind     = sd_reg[W].kind;
        ds_next.d        = sq_root[W];
        ds_next.dz       = (sq_root[W] == '0);
    end

    logic [W-1:0] n_rem_reg [3];
    extent_t      n_num_reg [3];

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            ds_reg[0] <= ds_next;
            for (int i = 0; i < 3; i++)
            begin
                n_rem_reg[i] <= n_rem_next[i];
                n_num_reg[i] <= n_num_next[i];
            end
            for (int k = 1; k <= QB; k++)
                ds_reg[k] <= ds_reg[k-1];
        end
    end

    for (genvar i = 0; i < 3; i++)
    begin : g_lane
        assign dv_rem[i][0] = n_rem_reg[i];
        assign dv_num[i][0] = n_num_reg[i];
        assign dv_q[i][0]   = '0;
        for (genvar k = 0; k < QB; k++)
        begin : g_div
            cssq_div_cell #(.W(W)) u_cell (
                .clk     (clk),
                .en      (adv),
                .d       (ds_reg[k].d),
                .rem_in  (dv_rem[i][k]),
                .num_in  (dv_num[i][k]),
                .q_in    (dv_q[i][k]),
                .rem_out (dv_rem[i][k+1]),
                .num_out (dv_num[i][k+1]),
                .q_out   (dv_q[i][k+1])
            );
        end
    end

    // valid chain through every stage
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
            s2_valid_reg <= 1'b0;
            for (int k = 0; k <= W; k++)
                vq_reg[k] <= 1'b0;
            for (int k = 0; k <= QB; k++)
                vd_reg[k] <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else if (adv)
        begin
            s1_valid_reg <= query.valid;
            s2_valid_reg <= s1_valid_reg;
            vq_reg[0]    <= s2_valid_reg;
            for (int k = 1; k <= W; k++)
                vq_reg[k] <= vq_reg[k-1];
            vd_reg[0] <= vq_reg[W];
            for (int k = 1; k <= QB; k++)
                vd_reg[k] <= vd_reg[k-1];
            out_valid_reg <= vd_reg[QB];
        end
    end

    // final assembly and saturation
    logic [W-1:0]      sup_next [3], prj_next [3];
    logic [W-1:0]      sup_reg  [3], prj_reg  [3];
    logic              in_shape_reg;
    logic [KIND_W-1:0] out_kind_reg;

    always_comb
    begin
        logic [W-1:0] scaled;
        for (int i = 0; i < 3; i++)
        begin
            scaled = sat(ds_reg[QB].neg[i], dv_q[i][QB]);
            if (ds_reg[QB].rad[i])
            begin
                // zero radial direction gives a zero support component
                sup_next[i] = ds_reg[QB].dz ? '0 : scaled;
                prj_next[i] = ds_reg[QB].outside ? scaled : ds_reg[QB].fprj[i];
            end
            else
            begin
                sup_next[i] = ds_reg[QB].fsup[i];
                prj_next[i] = ds_reg[QB].fprj[i];
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            for (int i = 0; i < 3; i++)
            begin
                sup_reg[i] <= sup_next[i];
                prj_reg[i] <= prj_next[i];
            end
            in_shape_reg <= ds_reg[QB].in_shape;
            out_kind_reg <= ds_reg[QB].kind;
        end
    end

    assign result.valid      = out_valid_reg;
    assign result.support_x  = sup_reg[0];
    assign result.support_y  = sup_reg[1];
    assign result.support_z  = sup_reg[2];
    assign result.proj_x     = prj_reg[0];
    assign result.proj_y     = prj_reg[1];
    assign result.proj_z     = prj_reg[2];
    assign result.inside_res = in_shape_reg;

    `ASSERT_IMPL(a_stall_blocks_input, result.valid && !result.ready, !query.ready, "input taken during output stall")
    `ASSERT_NEXT(a_accept_captured, query.valid && query.ready, s1_valid_reg, "accepted transaction not captured")
    `ASSERT_IMPL(a_unused_kind_zero, result.valid && out_kind_reg == KIND_NONE, !result.inside_res && result.support_x == '0 && result.proj_z == '0, "unused shape gave nonzero result")
endmodule

`default_nettype wire
